// ===== hw/rtl/at_command_frame_extractor_assert.svh =====
// Assertion macros for the AT command frame extractor.
`ifndef AT_COMMAND_FRAME_EXTRACTOR_ASSERT_SVH
`define AT_COMMAND_FRAME_EXTRACTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define AT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/acfe_pkg.sv =====
// Package with constants for the AT command frame extractor.
package acfe_pkg;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam int MIN_LINE = 5;
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;
    typedef logic [7:0] t_byte;
endpackage

// ===== hw/rtl/at_command_frame_extractor.sv =====
// Top level of the AT command frame extractor.
// Each command (start while not busy) yields one result, shown with o_done for one
// cycle. A read passes through S_RRD and S_RDAT (registered length and frame-store
// reads) before S_DONE; a read with an empty FIFO, or a byte refused because the line
// buffer is full, goes straight to S_DONE. A received byte that is not CR/LF, or a
// terminator on a short line, passes through S_CHK. A terminator that triggers
// extraction scans the line buffer byte by byte (read, then compare): backward from
// the end to the last "AT+", forward to the first terminator, then copies the frame
// byte by byte (read, then write) through the single line-buffer read port. The
// receiver cannot stall; results are never held.
`include "at_command_frame_extractor_assert.svh"
module at_command_frame_extractor #(
    parameter int FIFO_SLOTS  = 4,
    parameter int FRAME_BYTES = 128,
    parameter int LINE_BYTES  = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    output logic       o_done,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    output logic       o_frame_stored,
    output logic       o_frame_dropped,
    output logic       o_rx_overflow,
    output logic [8:0] o_line_count,
    output logic       o_frame_pending,
    output logic       o_read_valid,
    output logic [7:0] o_read_data,
    output logic       o_read_last
);
    localparam int LAW = $clog2(LINE_BYTES);
    localparam int LFW = $clog2(LINE_BYTES + 1);
    localparam int SW  = $clog2(FIFO_SLOTS);
    localparam int OW  = $clog2(FRAME_BYTES);
    localparam int FLW = $clog2(FRAME_BYTES);
    localparam int FAW = SW + OW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WAIT  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_BRD   = 4'd3;
    localparam logic [3:0] S_BCHK  = 4'd4;
    localparam logic [3:0] S_FRD   = 4'd5;
    localparam logic [3:0] S_FCHK  = 4'd6;
    localparam logic [3:0] S_CRD   = 4'd7;
    localparam logic [3:0] S_CWR   = 4'd8;
    localparam logic [3:0] S_RRD   = 4'd9;
    localparam logic [3:0] S_RDAT  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [7:0]       r_line [LINE_BYTES];
    logic [7:0]       r_fstore [FIFO_SLOTS << OW];
    logic [FLW-1:0]   r_flen [FIFO_SLOTS];

    logic [3:0]       r_state, n_state;
    logic [LFW-1:0]   r_fill, n_fill;
    logic [SW-1:0]    r_wslot, n_wslot, r_rslot, n_rslot;
    logic [OW-1:0]    r_roff, n_roff;
    logic [LFW-1:0]   r_ptr, n_ptr;
    logic [LFW-1:0]   r_start, n_start;
    logic [FLW-1:0]   r_cnt, n_cnt;
    logic [FLW-1:0]   r_len, n_len;
    logic [1:0]       r_match, n_match;
    logic             r_stored, n_stored, r_dropped, n_dropped, r_ovf, n_ovf;
    logic             r_rvalid, n_rvalid, r_rlast, n_rlast;
    logic [7:0]       r_rdata, n_rdata;

    logic             line_we;
    logic [LAW-1:0]   line_waddr, line_raddr;
    logic [7:0]       line_wdata, line_q;
    logic             fs_we;
    logic [FAW-1:0]   fs_waddr, fs_raddr;
    logic [7:0]       fs_q;
    logic             fl_we;
    logic [FLW-1:0]   fl_q;
    logic [7:0]       r_last_byte;

    always_ff @(posedge i_clk) begin
        if (line_we) r_line[line_waddr] <= line_wdata;
        line_q <= r_line[line_raddr];
        if (fs_we) r_fstore[fs_waddr] <= line_q;
        fs_q <= r_fstore[fs_raddr];
        if (fl_we) r_flen[r_wslot] <= r_len;
        fl_q <= r_flen[r_rslot];
    end

    function automatic logic is_eol(input logic [7:0] c);
        return c == acfe_pkg::CH_CR || c == acfe_pkg::CH_LF;
    endfunction

    logic [SW-1:0] wnext;
    logic [OW-1:0] off_sat;
    always_comb begin
        wnext = (r_wslot == SW'(FIFO_SLOTS - 1)) ? '0 : r_wslot + 1'b1;
        off_sat = r_roff;
    end

    always_comb begin
        n_state = r_state; n_fill = r_fill; n_wslot = r_wslot; n_rslot = r_rslot;
        n_roff = r_roff; n_ptr = r_ptr; n_start = r_start; n_cnt = r_cnt; n_len = r_len;
        n_match = r_match; n_stored = r_stored; n_dropped = r_dropped; n_ovf = r_ovf;
        n_rvalid = r_rvalid; n_rlast = r_rlast; n_rdata = r_rdata;
        line_we = 1'b0; line_waddr = r_fill[LAW-1:0]; line_wdata = i_rx_byte;
        line_raddr = r_ptr[LAW-1:0];
        fs_we = 1'b0; fs_waddr = {r_wslot, r_cnt[OW-1:0]};
        fs_raddr = {r_rslot, off_sat};
        fl_we = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_stored = 1'b0; n_dropped = 1'b0; n_ovf = 1'b0;
                    n_rvalid = 1'b0; n_rlast = 1'b0; n_rdata = '0;
                    if (i_op == acfe_pkg::OP_RX) begin
                        if (r_fill >= LFW'(LINE_BYTES)) begin
                            n_ovf = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            line_we = 1'b1;
                            n_fill = r_fill + 1'b1;
                            n_state = S_CHK;
                        end
                    end else if (r_rslot != r_wslot) begin
                        n_state = S_RRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CHK: begin
                if (r_fill >= LFW'(acfe_pkg::MIN_LINE) && is_eol(r_last_byte)) begin
                    n_ptr = r_fill - LFW'(1);
                    n_match = 2'd0;
                    n_state = S_BRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BRD: n_state = S_BCHK;
            S_BCHK: begin
                // backward matching of "+", "T", "A" ending at fill-2 or earlier
                if (r_match == 2'd0 && r_ptr == r_fill - LFW'(1)) begin
                    n_match = 2'd0;
                end else if (r_match == 2'd0 && line_q == acfe_pkg::CH_PLUS) begin
                    n_match = 2'd1;
                end else if (r_match == 2'd1 && line_q == acfe_pkg::CH_T) begin
                    n_match = 2'd2;
                end else if (r_match == 2'd2 && line_q == acfe_pkg::CH_A) begin
                    n_match = 2'd3;
                end else begin
                    n_match = (line_q == acfe_pkg::CH_PLUS) ? 2'd1 : 2'd0;
                end
                if (n_match == 2'd3) begin
                    n_start = r_ptr;
                    n_ptr = r_ptr + LFW'(3);
                    n_state = S_FRD;
                end else if (r_ptr == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr - 1'b1;
                    n_state = S_BRD;
                end
            end
            S_FRD: n_state = S_FCHK;
            S_FCHK: begin
                if (is_eol(line_q)) begin
                    n_fill = r_start;
                    if (wnext == r_rslot) begin
                        n_dropped = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        if (r_ptr - r_start + 1'b1 > LFW'(FRAME_BYTES - 1))
                            n_len = FLW'(FRAME_BYTES - 1);
                        else
                            n_len = FLW'(r_ptr - r_start + 1'b1);
                        n_cnt = '0;
                        n_ptr = r_start;
                        n_state = S_CRD;
                    end
                end else begin
                    n_ptr = r_ptr + 1'b1;
                    n_state = S_FRD;
                end
            end
            S_CRD: begin
                n_ptr = r_ptr + 1'b1;
                n_state = S_CWR;
            end
            S_CWR: begin
                fs_we = 1'b1;
                if (r_cnt + 1'b1 == r_len) begin
                    fl_we = 1'b1;
                    n_wslot = wnext;
                    n_stored = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_state = S_CRD;
                end
            end
            S_RRD: n_state = S_RDAT;
            S_RDAT: begin
                n_rvalid = 1'b1;
                n_rdata = fs_q;
                if ({1'b0, r_roff} + 1'b1 >= {1'b0, fl_q}) begin
                    n_rlast = 1'b1;
                    n_roff = '0;
                    n_rslot = (r_rslot == SW'(FIFO_SLOTS - 1)) ? '0 : r_rslot + 1'b1;
                end else begin
                    n_roff = r_roff + 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_fill <= '0; r_wslot <= '0; r_rslot <= '0; r_roff <= '0;
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_wslot <= n_wslot;
            r_rslot <= n_rslot; r_roff <= n_roff;
        end
        r_ptr <= n_ptr; r_start <= n_start; r_cnt <= n_cnt; r_len <= n_len;
        r_match <= n_match; r_stored <= n_stored; r_dropped <= n_dropped;
        r_ovf <= n_ovf; r_rvalid <= n_rvalid; r_rlast <= n_rlast; r_rdata <= n_rdata;
        if (line_we) r_last_byte <= i_rx_byte;
    end

    assign busy            = r_state != S_IDLE;
    assign o_done          = r_state == S_DONE;
    assign o_frame_stored  = r_stored;
    assign o_frame_dropped = r_dropped;
    assign o_rx_overflow   = r_ovf;
    assign o_line_count    = 9'(r_fill);
    assign o_frame_pending = r_rslot != r_wslot;
    assign o_read_valid    = r_rvalid;
    assign o_read_data     = r_rdata;
    assign o_read_last     = r_rlast;

    `AT_ASSERT_IMPL(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= LFW'(LINE_BYTES))
    `AT_ASSERT_IMPL(a_done_flags, i_clk, i_rst_n, o_done, !(r_stored && r_dropped))
    `AT_ASSERT_IMPL(a_last_valid, i_clk, i_rst_n, o_done && r_rlast, r_rvalid)
    `AT_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy)
endmodule

// ===== sim/at_command_frame_extractor_checker.sv =====
// Checker for the AT command frame extractor: predicts every result and compares it.
module at_command_frame_extractor_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       o_done,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    input  logic       o_frame_stored,
    input  logic       o_frame_dropped,
    input  logic       o_rx_overflow,
    input  logic [8:0] o_line_count,
    input  logic       o_frame_pending,
    input  logic       o_read_valid,
    input  logic [7:0] o_read_data,
    input  logic       o_read_last,
    output int         o_fail_count,
    output int         o_outstanding
);
    localparam int SLOTS     = 4;
    localparam int FRM_BYTES = 128;
    localparam int LN_BYTES  = 256;

    typedef struct packed {
        logic            stored;
        logic            dropped;
        logic            overflow;
        logic [8:0]      count;
        logic            pending;
        logic            rvalid;
        acfe_pkg::t_byte rdata;
        logic            rlast;
    } t_step_result;

    acfe_pkg::t_byte line_buf [LN_BYTES];
    int              line_fill;
    acfe_pkg::t_byte frames [SLOTS][FRM_BYTES];
    int              frame_len [SLOTS];
    logic [1:0]      wr_slot;
    logic [1:0]      rd_slot;
    int              rd_off;
    t_step_result    expected_q[$];
    int              fails;

    function automatic logic is_term(acfe_pkg::t_byte c);
        return c == acfe_pkg::CH_CR || c == acfe_pkg::CH_LF;
    endfunction

    task automatic field_check(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    task automatic apply_command(logic op, acfe_pkg::t_byte b);
        t_step_result r;
        int           st;
        int           stop;
        int           len;
        int           k;
        logic [1:0]   nxt;
        r = '0;
        if (op == acfe_pkg::OP_RX) begin
            if (line_fill >= LN_BYTES) begin
                r.overflow = 1'b1;
            end else begin
                line_buf[line_fill] = b;
                line_fill++;
                if (line_fill >= acfe_pkg::MIN_LINE && is_term(line_buf[line_fill-1])) begin
                    st = line_fill - 3;
                    while (st >= 0 && !(line_buf[st] == acfe_pkg::CH_A &&
                                        line_buf[st+1] == acfe_pkg::CH_T &&
                                        line_buf[st+2] == acfe_pkg::CH_PLUS))
                        st--;
                    stop = -1;
                    if (st >= 0) begin
                        k = st + 2;
                        while (k < line_fill && stop < 0) begin
                            if (is_term(line_buf[k]))
                                stop = k;
                            k++;
                        end
                    end
                    if (stop >= 0) begin
                        line_fill = st;
                        nxt = wr_slot + 2'd1;
                        if (nxt == rd_slot) begin
                            r.dropped = 1'b1;
                        end else begin
                            len = stop + 1 - st;
                            if (len > FRM_BYTES - 1)
                                len = FRM_BYTES - 1;
                            for (int i = 0; i < len; i++)
                                frames[wr_slot][i] = line_buf[st+i];
                            frame_len[wr_slot] = len;
                            wr_slot = nxt;
                            r.stored = 1'b1;
                        end
                    end
                end
            end
        end else if (rd_slot != wr_slot) begin
            r.rvalid = 1'b1;
            r.rdata  = frames[rd_slot][rd_off];
            if (rd_off + 1 >= frame_len[rd_slot]) begin
                r.rlast = 1'b1;
                rd_off  = 0;
                rd_slot = rd_slot + 2'd1;
            end else begin
                rd_off++;
            end
        end
        r.count   = line_fill[8:0];
        r.pending = rd_slot != wr_slot;
        expected_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_step_result e;
        if (!i_rst_n) begin
            line_fill = 0;
            wr_slot   = '0;
            rd_slot   = '0;
            rd_off    = 0;
            fails     = 0;
            expected_q.delete();
        end else begin
            if (o_done) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    fails++;
                end else begin
                    e = expected_q.pop_front();
                    field_check("frame_stored", e.stored, o_frame_stored);
                    field_check("frame_dropped", e.dropped, o_frame_dropped);
                    field_check("rx_overflow", e.overflow, o_rx_overflow);
                    field_check("line_count", e.count, o_line_count);
                    field_check("frame_pending", e.pending, o_frame_pending);
                    field_check("read_valid", e.rvalid, o_read_valid);
                    field_check("read_data", e.rdata, o_read_data);
                    field_check("read_last", e.rlast, o_read_last);
                end
            end
            if (start && !busy)
                apply_command(i_op, i_rx_byte);
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_q.size();
    end
endmodule

// ===== sim/at_command_frame_extractor_tb.sv =====
// Testbench top for the AT command frame extractor: stimulus, clock, reset and verdict.
module at_command_frame_extractor_tb;
    localparam int CYCLE_LIMIT = 4000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       i_op = acfe_pkg::OP_RX;
    logic [7:0] i_rx_byte = '0;
    logic       busy, o_done;
    logic       o_frame_stored, o_frame_dropped, o_rx_overflow;
    logic [8:0] o_line_count;
    logic       o_frame_pending, o_read_valid, o_read_last;
    logic [7:0] o_read_data;
    int         fail_count, outstanding;
    int         idle_pct;
    int         sent;
    int         lines_sent;
    int         cycles;

    always #5 i_clk = ~i_clk;

    at_command_frame_extractor u_top (.*);

    at_command_frame_extractor_checker u_checker (
        .o_fail_count (fail_count),
        .o_outstanding(outstanding),
        .*
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("at_command_frame_extractor regression: fail");
            $finish;
        end
    end

    task automatic issue(logic op, acfe_pkg::t_byte b);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge i_clk);
        end
        start     <= 1'b1;
        i_op      <= op;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            issue(acfe_pkg::OP_RX, s[i]);
    endtask

    function automatic acfe_pkg::t_byte body_byte();
        if ($urandom_range(9) == 0)
            return acfe_pkg::t_byte'($urandom_range(255));
        return acfe_pkg::t_byte'($urandom_range(8'h7e, 8'h20));
    endfunction

    task automatic send_line();
        int plen;
        plen = ($urandom_range(29) == 0) ? $urandom_range(150, 115) : $urandom_range(20);
        if ($urandom_range(9) == 0)
            issue(acfe_pkg::OP_RX, body_byte());
        send_text("AT+");
        repeat (plen)
            issue(acfe_pkg::OP_RX, body_byte());
        issue(acfe_pkg::OP_RX, $urandom_range(1) ? acfe_pkg::CH_CR : acfe_pkg::CH_LF);
        if ($urandom_range(7) == 0)
            issue(acfe_pkg::OP_RX, $urandom_range(1) ? acfe_pkg::CH_LF : body_byte());
        lines_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0 || o_done)
            @(posedge i_clk);
    endtask

    initial begin
        idle_pct = 8;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty read, short lines, minimum frame, both terminators, byte extremes
        issue(acfe_pkg::OP_READ, 8'hff);
        issue(acfe_pkg::OP_RX, acfe_pkg::CH_CR);
        send_text("AT+\n");
        issue(acfe_pkg::OP_RX, 8'h00);
        issue(acfe_pkg::OP_RX, 8'hff);
        send_text("AT+X\r");
        send_text("AT+\r\n");
        repeat (8)
            issue(acfe_pkg::OP_READ, '0);
        wait_drained();

        while (sent < 470) begin
            if (sent > 330)
                idle_pct = 0;
            else if (sent > 180)
                idle_pct = 45;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: send_line();
                6, 7, 8: repeat ($urandom_range(25, 1)) issue(acfe_pkg::OP_READ, body_byte());
                default: issue(acfe_pkg::OP_RX, body_byte());
            endcase
        end

        // fill the line buffer until bytes are refused, terminator included
        repeat (262)
            issue(acfe_pkg::OP_RX, 8'h5a);
        issue(acfe_pkg::OP_RX, acfe_pkg::CH_CR);
        repeat (20)
            issue(acfe_pkg::OP_READ, '0);
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0 || o_done)
            @(posedge i_clk);
        repeat (1200) @(posedge i_clk);

        $display("Ran %0d transfers including %0d AT+ lines, long frames, FIFO full drops,",
                 sent, lines_sent);
        $display("line buffer overflow and empty reads under three sender idle profiles.");
        if (fail_count == 0)
            $display("at_command_frame_extractor regression: pass");
        else
            $display("at_command_frame_extractor regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/acfe_pkg.sv
hw/rtl/at_command_frame_extractor.sv
sim/at_command_frame_extractor_checker.sv
sim/at_command_frame_extractor_tb.sv
